// ----- design/vwpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vwpd_pkg: shared types, constants and control store
// Item formats, result and status codes, and the control program that runs
// the windowed percent-difference query.
// ----------------------------------------------------------------------------
package vwpd_pkg;

  // Default build parameters
  localparam int SIDE_DEF        = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed-point result constants (1/256 percent)
  localparam logic [15:0] UNIT_EQUAL = 16'd25600;
  localparam logic [15:0] UNIT_MAX   = 16'd51200;

  // Quotient width of the long division and its iteration counter
  localparam int Q_BITS    = 17;
  localparam int DCNT_BITS = $clog2(Q_BITS + 1);

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIM_X  = 2'd0;
  localparam logic [1:0] CFG_DIM_Y  = 2'd1;
  localparam logic [1:0] CFG_DIM_Z  = 2'd2;
  localparam logic [1:0] CFG_RADIUS = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BAND   = 2'd1,
    STAT_CENTRE = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [4:0]  pos_z;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic [15:0] diff_percent;
    status_t     status;
  } out_item_t;

  // Program steps
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_CHECK  = 4'd1,
    ST_CENTRE = 4'd2,
    ST_SCAN   = 4'd3,
    ST_LAST   = 4'd4,
    ST_DIFF   = 4'd5,
    ST_DLOAD  = 4'd6,
    ST_DIV    = 4'd7,
    ST_DONE   = 4'd8,
    ST_BAND   = 4'd9,
    ST_CZERO  = 4'd10,
    ST_EMIT   = 4'd11
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER   = 3'd0,
    C_NOSTART = 3'd1,
    C_BORDER  = 3'd2,
    C_CZERO   = 3'd3,
    C_WINMORE = 3'd4,
    C_DIVMORE = 3'd5,
    C_OUTFULL = 3'd6,
    C_ALWAYS  = 3'd7
  } cond_t;

  // Result selection
  typedef enum logic [1:0] {
    R_NONE  = 2'd0,
    R_CALC  = 2'd1,
    R_BAND  = 2'd2,
    R_CZERO = 2'd3
  } res_sel_t;

  // One control word
  typedef struct packed {
    cond_t    cond;
    step_t    jmp;
    step_t    nxt;
    logic     ready;     // input channel open
    logic     addr_win;  // read window voxel instead of centre
    logic     clr;       // clear sums and window counters
    logic     cnt_step;  // advance window counters
    logic     acc;       // accumulate last read pair
    logic     dp_diff;   // form |s2-s1| and direction
    logic     div_load;  // load the divider
    logic     div_step;  // one quotient bit
    res_sel_t res_sel;
    logic     emit;      // hand result to output register
  } ctrl_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic border;
    logic czero;
    logic win_more;
    logic div_more;
  } dp_flags_t;

  // Control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w          = '0;
    w.cond     = C_NEVER;
    w.jmp      = ST_IDLE;
    w.nxt      = ST_IDLE;
    w.res_sel  = R_NONE;
    case (s)
      ST_IDLE: begin
        w.ready = 1'b1;
        w.cond  = C_NOSTART;
        w.jmp   = ST_IDLE;
        w.nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        w.cond = C_BORDER;
        w.jmp  = ST_BAND;
        w.nxt  = ST_CENTRE;
      end
      ST_CENTRE: begin
        w.clr  = 1'b1;
        w.cond = C_CZERO;
        w.jmp  = ST_CZERO;
        w.nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        w.addr_win = 1'b1;
        w.acc      = 1'b1;
        w.cnt_step = 1'b1;
        w.cond     = C_WINMORE;
        w.jmp      = ST_SCAN;
        w.nxt      = ST_LAST;
      end
      ST_LAST: begin
        w.acc = 1'b1;
        w.nxt = ST_DIFF;
      end
      ST_DIFF: begin
        w.dp_diff = 1'b1;
        w.nxt     = ST_DLOAD;
      end
      ST_DLOAD: begin
        w.div_load = 1'b1;
        w.nxt      = ST_DIV;
      end
      ST_DIV: begin
        w.div_step = 1'b1;
        w.cond     = C_DIVMORE;
        w.jmp      = ST_DIV;
        w.nxt      = ST_DONE;
      end
      ST_DONE: begin
        w.res_sel = R_CALC;
        w.nxt     = ST_EMIT;
      end
      ST_BAND: begin
        w.res_sel = R_BAND;
        w.nxt     = ST_EMIT;
      end
      ST_CZERO: begin
        w.res_sel = R_CZERO;
        w.nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUTFULL;
        w.jmp  = ST_EMIT;
        w.nxt  = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp  = ST_IDLE;
        w.nxt  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/volume_window_percent_difference.sv -----
// ----------------------------------------------------------------------------
// volume_window_percent_difference: windowed percent difference of two volumes
// Stores sample pairs into two voxel volumes and answers queries with the
// clamped ratio of window sums, 100*s2/s1 percent in 1/256 percent units.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | kind, pos_x/y/z, sample_a/b
//  out_     | output    | out_valid/out_stall | diff_percent, status
//  cfg_     | input     | cfg_we            | cfg_index, cfg_data
//
// A store item is taken whenever the block is idle.
// A query is taken in the idle step, then runs the border and centre tests,
// the window reads (one memory read per cycle), the difference and divider
// setup, the division steps of the 17-bit quotient, the result step and a
// hand-off that waits while the output register is full.
// Border and centre-zero queries skip the window reads and the division.
// Reset is synchronous; volume contents are not cleared. A stalled result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module volume_window_percent_difference #(
  parameter int SIDE        = vwpd_pkg::SIDE_DEF,
  parameter int SAMPLE_BITS = vwpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vwpd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output vwpd_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_data
);

  import vwpd_pkg::*;

  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [5:0] dim_x_r, dim_y_r, dim_z_r;
  logic [1:0] radius_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  ctrl_t                  ctrl;
  dp_flags_t              flags;
  out_item_t              res;
  logic                   accept;
  logic                   start;
  logic                   store_we;
  logic                   store_ok;
  logic                   out_full;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [SAMPLE_BITS-1:0] rd_a, rd_b;

  // Input handshake
  assign in_stall = !ctrl.ready;
  assign accept   = in_valid && ctrl.ready;
  assign start    = accept && (in_item.kind == KIND_QUERY);
  assign store_we = accept && (in_item.kind == KIND_STORE) && store_ok;
  assign out_full = out_valid_r && out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= 6'd32;
      dim_y_r  <= 6'd32;
      dim_z_r  <= 6'd32;
      radius_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM_X:  dim_x_r  <= cfg_data;
        CFG_DIM_Y:  dim_y_r  <= cfg_data;
        CFG_DIM_Z:  dim_z_r  <= cfg_data;
        CFG_RADIUS: radius_r <= cfg_data[1:0];
        default:    radius_r <= radius_r;
      endcase
    end
  end

  // Sample volumes
  vwpd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_first (
    .clk     (clk),
    .we      (store_we),
    .waddr   (waddr),
    .wdata   (SAMPLE_BITS'(in_item.sample_a)),
    .raddr   (raddr),
    .rd_data (rd_a)
  );

  vwpd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_second (
    .clk     (clk),
    .we      (store_we),
    .waddr   (waddr),
    .wdata   (SAMPLE_BITS'(in_item.sample_b)),
    .raddr   (raddr),
    .rd_data (rd_b)
  );

  // Sequencer
  vwpd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_full (out_full),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  // Datapath
  vwpd_dp #(.SIDE(SIDE), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_item  (in_item),
    .load_pos (start),
    .dim_x    (dim_x_r),
    .dim_y    (dim_y_r),
    .dim_z    (dim_z_r),
    .radius   (radius_r),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .raddr    (raddr),
    .waddr    (waddr),
    .store_ok (store_ok),
    .flags    (flags),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && !out_full) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_full) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/vwpd_ram.sv -----
// ----------------------------------------------------------------------------
// vwpd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vwpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/vwpd_seq.sv -----
// ----------------------------------------------------------------------------
// vwpd_seq: microcode sequencer
// Step counter, control store lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module vwpd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,     // query item accepted
  input  logic                out_full,  // output register cannot take a result
  input  vwpd_pkg::dp_flags_t flags,
  output vwpd_pkg::ctrl_t     ctrl
);

  import vwpd_pkg::*;

  step_t step_r, step_nxt;
  ctrl_t word;
  logic  take;

  // Control word of the current step
  always_comb begin
    word = ucode(step_r);
  end

  assign ctrl = word;

  // Condition select and next step
  always_comb begin
    case (word.cond)
      C_NEVER:   take = 1'b0;
      C_NOSTART: take = !start;
      C_BORDER:  take = flags.border;
      C_CZERO:   take = flags.czero;
      C_WINMORE: take = flags.win_more;
      C_DIVMORE: take = flags.div_more;
      C_OUTFULL: take = out_full;
      C_ALWAYS:  take = 1'b1;
      default:   take = 1'b1;
    endcase
    step_nxt = take ? word.jmp : word.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- design/vwpd_dp.sv -----
// ----------------------------------------------------------------------------
// vwpd_dp: query datapath
// Voxel addressing, border test, window accumulation, long division and
// result formatting, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module vwpd_dp #(
  parameter int SIDE        = vwpd_pkg::SIDE_DEF,
  parameter int SAMPLE_BITS = vwpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vwpd_pkg::ctrl_t                       ctrl,
  input  vwpd_pkg::in_item_t                    in_item,
  input  logic                                  load_pos,
  input  logic [5:0]                            dim_x,
  input  logic [5:0]                            dim_y,
  input  logic [5:0]                            dim_z,
  input  logic [1:0]                            radius,
  input  logic [SAMPLE_BITS-1:0]                rd_a,
  input  logic [SAMPLE_BITS-1:0]                rd_b,
  output logic [$clog2(SIDE*SIDE*SIDE)-1:0]     raddr,
  output logic [$clog2(SIDE*SIDE*SIDE)-1:0]     waddr,
  output logic                                  store_ok,
  output vwpd_pkg::dp_flags_t                   flags,
  output vwpd_pkg::out_item_t                   res
);

  import vwpd_pkg::*;

  localparam int AW = $clog2(SIDE * SIDE * SIDE);
  localparam int DW = ($clog2(SIDE + 1) > 7) ? $clog2(SIDE + 1) : 7;
  localparam int SW = SAMPLE_BITS + 7;   // sum of up to 125 samples
  localparam int NW = SW + 15;           // times 25600
  localparam logic [DW-1:0] SIDE_D   = DW'(SIDE);
  localparam logic [AW-1:0] STRIDE_Y = AW'(SIDE);
  localparam logic [AW-1:0] STRIDE_Z = AW'(SIDE * SIDE);

  // Linear voxel address, x fastest
  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
                                            input logic [5:0] z);
    return AW'(x) + STRIDE_Y * AW'(y) + STRIDE_Z * AW'(z);
  endfunction

  // Dimension register clamped to 1..SIDE
  function automatic logic [DW-1:0] eff_dim(input logic [5:0] d);
    logic [DW-1:0] dw;
    dw = DW'(d);
    if (dw == '0) return DW'(1);
    if (dw > SIDE_D) return SIDE_D;
    return dw;
  endfunction

  // Position within radius of either face of an axis
  function automatic logic in_band(input logic [4:0] p, input logic [1:0] r,
                                   input logic [5:0] d);
    logic [DW-1:0] pw;
    logic [DW-1:0] rw;
    pw = DW'(p);
    rw = DW'(r);
    return (pw < rw) || (pw + rw >= eff_dim(d));
  endfunction

  logic [4:0]           px_r, py_r, pz_r;
  logic [2:0]           di_r, dj_r, dk_r;
  logic                 pend_r;
  logic [SW-1:0]        s1_r, s2_r;
  logic                 up_r;
  logic [SW-1:0]        diff_r;
  logic [SW-1:0]        rem_r;
  logic [Q_BITS-1:0]    nlo_r;
  logic [Q_BITS-1:0]    q_r;
  logic                 ovf_r;
  logic [DCNT_BITS-1:0] dcnt_r;
  out_item_t            res_r;

  logic [1:0]    r_eff;
  logic [2:0]    span;
  logic          last;
  logic [5:0]    wx, wy, wz;
  logic [NW-1:0] num;
  logic [NW-1:0] num_hi;
  logic [SW:0]   trial;
  logic          trial_ge;
  logic [15:0]   calc_val;

  // Radius 3 acts as 2
  assign r_eff = (radius == 2'd3) ? 2'd2 : radius;
  assign span  = {r_eff, 1'b0};
  assign last  = (di_r == span) && (dj_r == span) && (dk_r == span);

  // Window voxel coordinates
  assign wx = {1'b0, px_r} - {4'b0, r_eff} + {3'b0, di_r};
  assign wy = {1'b0, py_r} - {4'b0, r_eff} + {3'b0, dj_r};
  assign wz = {1'b0, pz_r} - {4'b0, r_eff} + {3'b0, dk_r};

  // Memory addressing
  assign raddr = ctrl.addr_win ? addr_of(wx, wy, wz)
                               : addr_of({1'b0, px_r}, {1'b0, py_r}, {1'b0, pz_r});
  assign waddr = addr_of({1'b0, in_item.pos_x}, {1'b0, in_item.pos_y},
                         {1'b0, in_item.pos_z});
  assign store_ok = (DW'(in_item.pos_x) < SIDE_D) && (DW'(in_item.pos_y) < SIDE_D) &&
                    (DW'(in_item.pos_z) < SIDE_D);

  // Status toward the sequencer
  assign flags.border   = in_band(px_r, r_eff, dim_x) || in_band(py_r, r_eff, dim_y) ||
                          in_band(pz_r, r_eff, dim_z);
  assign flags.czero    = (rd_a == '0) || (rd_b == '0);
  assign flags.win_more = !last;
  assign flags.div_more = (dcnt_r != DCNT_BITS'(1));

  // 25600 * diff as shifts: (16384 + 8192 + 1024) * diff
  assign num    = (NW'(diff_r) << 14) + (NW'(diff_r) << 13) + (NW'(diff_r) << 10);
  assign num_hi = num >> Q_BITS;

  // One restoring division step
  assign trial    = {rem_r, nlo_r[Q_BITS-1]};
  assign trial_ge = trial >= {1'b0, s1_r};

  // Final value from quotient and direction
  always_comb begin
    if (up_r) begin
      if (ovf_r || (q_r > Q_BITS'(UNIT_MAX - UNIT_EQUAL))) begin
        calc_val = UNIT_MAX;
      end else begin
        calc_val = UNIT_EQUAL + q_r[15:0];
      end
    end else begin
      calc_val = UNIT_EQUAL - q_r[15:0];
    end
  end

  // Query position
  always_ff @(posedge clk) begin
    if (load_pos) begin
      px_r <= in_item.pos_x;
      py_r <= in_item.pos_y;
      pz_r <= in_item.pos_z;
    end
  end

  // Window counters and read-pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      di_r   <= '0;
      dj_r   <= '0;
      dk_r   <= '0;
      pend_r <= 1'b0;
    end else if (ctrl.clr) begin
      di_r   <= '0;
      dj_r   <= '0;
      dk_r   <= '0;
      pend_r <= 1'b0;
    end else if (ctrl.cnt_step) begin
      pend_r <= 1'b1;
      if (di_r == span) begin
        di_r <= '0;
        if (dj_r == span) begin
          dj_r <= '0;
          dk_r <= dk_r + 3'd1;
        end else begin
          dj_r <= dj_r + 3'd1;
        end
      end else begin
        di_r <= di_r + 3'd1;
      end
    end
  end

  // Window sums over pairs with both samples positive
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (ctrl.acc && pend_r && (rd_a != '0) && (rd_b != '0)) begin
      s1_r <= s1_r + SW'(rd_a);
      s2_r <= s2_r + SW'(rd_b);
    end
  end

  // Difference magnitude and direction
  always_ff @(posedge clk) begin
    if (ctrl.dp_diff) begin
      up_r   <= (s2_r >= s1_r);
      diff_r <= (s2_r >= s1_r) ? (s2_r - s1_r) : (s1_r - s2_r);
    end
  end

  // Long division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (ctrl.div_load) begin
      dcnt_r <= DCNT_BITS'(Q_BITS);
    end else if (ctrl.div_step) begin
      dcnt_r <= dcnt_r - DCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      rem_r <= SW'(num_hi);
      nlo_r <= num[Q_BITS-1:0];
      ovf_r <= (num_hi >= NW'(s1_r));
      q_r   <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= trial_ge ? SW'(trial - {1'b0, s1_r}) : SW'(trial);
      nlo_r <= {nlo_r[Q_BITS-2:0], 1'b0};
      q_r   <= {q_r[Q_BITS-2:0], trial_ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    case (ctrl.res_sel)
      R_CALC: begin
        res_r.diff_percent <= calc_val;
        res_r.status       <= STAT_OK;
      end
      R_BAND: begin
        res_r.diff_percent <= '0;
        res_r.status       <= STAT_BAND;
      end
      R_CZERO: begin
        res_r.diff_percent <= '0;
        res_r.status       <= STAT_CENTRE;
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ----- dv/volume_window_percent_difference_test.sv -----
// ----------------------------------------------------------------------------
// volume_window_percent_difference_test: self-checking bench for the block
// Loads sample pairs into both volumes and queries windowed percent
// differences. A directed table covers border, centre and clamp cases, then
// random phases run over several dimension and radius settings. Each result
// is compared against a typed table value or an in-bench window-sum predictor.
// ----------------------------------------------------------------------------
module volume_window_percent_difference_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vwpd_pkg::*;

  localparam int VOXELS        = SIDE_DEF * SIDE_DEF * SIDE_DEF;
  localparam int MAX_POS       = SIDE_DEF - 1;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 180;
  localparam int HUB           = 16;  // centre of the preloaded window

  // Directed items: kind, x, y, z, sample_a, sample_b, typed, diff, status.
  // Rows with typed = 0 are checked against the predictor.
  localparam int DIR_ROWS = 24;
  localparam int DIRECTED [DIR_ROWS][9] = '{
    // border band on each face, reset radius 1
    '{KIND_QUERY,  0,  5,  5,     0,     0, 1,     0, STAT_BAND},
    '{KIND_QUERY, 31,  5,  5, 65535, 65535, 1,     0, STAT_BAND},
    '{KIND_QUERY,  5,  0,  5,     0,     0, 1,     0, STAT_BAND},
    '{KIND_QUERY,  5,  5, 31,     0,     0, 1,     0, STAT_BAND},
    '{KIND_QUERY, 31, 31, 31,     0,     0, 1,     0, STAT_BAND},
    '{KIND_QUERY,  0,  0,  0,     0,     0, 1,     0, STAT_BAND},
    // uniform window reads as equal
    '{KIND_QUERY, 16, 16, 16,     0,     0, 1, 25600, STAT_OK},
    // centre not positive, either volume
    '{KIND_STORE, 16, 16, 16,     0,     5, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 1,     0, STAT_CENTRE},
    '{KIND_STORE, 16, 16, 16,     5,     0, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 1,     0, STAT_CENTRE},
    // full-scale centre, still equal
    '{KIND_STORE, 16, 16, 16, 65535, 65535, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 1, 25600, STAT_OK},
    // large second volume saturates at the top
    '{KIND_STORE, 16, 16, 16,     1, 65535, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 1, 51200, STAT_OK},
    // large first volume, truncated downward quotient
    '{KIND_STORE, 16, 16, 16, 65535,     1, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 0,     0, STAT_OK},
    // neighbour with a zero sample drops out of both sums
    '{KIND_STORE, 17, 16, 16,     0,     9, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 0,     0, STAT_OK},
    '{KIND_STORE, 15, 15, 15, 32768,     1, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16, 65535, 65535, 0,     0, STAT_OK},
    '{KIND_STORE, 16, 16, 16,   200,   100, 0,     0, STAT_OK},
    '{KIND_QUERY, 16, 16, 16,     0,     0, 0,     0, STAT_OK},
    '{KIND_QUERY, 17, 17, 17,     0,     0, 0,     0, STAT_OK}
  };

  // Register settings per random phase: dim_x, dim_y, dim_z, radius
  localparam int N_PHASES = 6;
  localparam int PHASES [N_PHASES][4] = '{
    '{32, 32, 32, 2},
    '{12,  9, 40, 1},
    '{ 5,  5,  5, 2},
    '{ 0, 63,  1, 0},
    '{32, 32, 32, 3},
    '{ 7, 16, 32, 0}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = CFG_DIM_X;
  logic [5:0] cfg_data  = '0;

  volume_window_percent_difference dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of both volumes and the registers
  logic [15:0] first_vol  [VOXELS];
  logic [15:0] second_vol [VOXELS];
  bit          loaded     [VOXELS];
  logic [5:0]  dim_reg    [3];
  logic [1:0]  radius_reg;

  out_item_t   due_results [$];
  int          items_sent   = 0;
  int          results_seen = 0;
  int          errors       = 0;
  int          send_idle    = 0;
  int          recv_idle    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int vox(input int x, input int y, input int z);
    return x + SIDE_DEF * (y + SIDE_DEF * z);
  endfunction

  function automatic int eff_dim(input logic [5:0] d);
    if (d == 6'd0) return 1;
    if (d > SIDE_DEF) return SIDE_DEF;
    return int'(d);
  endfunction

  function automatic int eff_radius();
    return (radius_reg > 2'd2) ? 2 : int'(radius_reg);
  endfunction

  function automatic bit in_border(input int x, input int y, input int z);
    int p [3];
    int r;
    int a;
    p = '{x, y, z};
    r = eff_radius();
    for (a = 0; a < 3; a++) begin
      if (p[a] < r || p[a] + r >= eff_dim(dim_reg[a])) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Clamped ratio of window sums, in 1/256 percent
  function automatic out_item_t percent_of_window(input int x, input int y, input int z);
    out_item_t res;
    longint    s1, s2, q;
    int        r, c, n, i, j, k;
    res.diff_percent = '0;
    if (in_border(x, y, z)) begin
      res.status = STAT_BAND;
      return res;
    end
    c = vox(x, y, z);
    if (first_vol[c] == '0 || second_vol[c] == '0) begin
      res.status = STAT_CENTRE;
      return res;
    end
    r  = eff_radius();
    s1 = 0;
    s2 = 0;
    for (k = z - r; k <= z + r; k++) begin
      for (j = y - r; j <= y + r; j++) begin
        for (i = x - r; i <= x + r; i++) begin
          n = vox(i, j, k);
          if (first_vol[n] != '0 && second_vol[n] != '0) begin
            s1 += first_vol[n];
            s2 += second_vol[n];
          end
        end
      end
    end
    res.status = STAT_OK;
    if (s2 >= s1) begin
      q = (longint'(UNIT_EQUAL) * (s2 - s1)) / s1;
      res.diff_percent = (q > longint'(UNIT_MAX - UNIT_EQUAL)) ? UNIT_MAX
                                                                : UNIT_EQUAL + 16'(q);
    end else begin
      q = (longint'(UNIT_EQUAL) * (s1 - s2)) / s1;
      res.diff_percent = (q > longint'(UNIT_EQUAL)) ? 16'd0 : UNIT_EQUAL - 16'(q);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    errors++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      flag_error($sformatf("unexpected result diff %0d status %0d",
                           got.diff_percent, got.status));
      return;
    end
    want = due_results.pop_front();
    if (got.diff_percent !== want.diff_percent)
      flag_error($sformatf("diff_percent %0d, expected %0d",
                           got.diff_percent, want.diff_percent));
    if (got.status !== want.status)
      flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_item);
      results_seen++;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic in_item_t make_item(input logic kind, input int x, input int y,
                                         input int z, input logic [15:0] a,
                                         input logic [15:0] b);
    in_item_t it;
    it.kind     = kind;
    it.pos_x    = 5'(x);
    it.pos_y    = 5'(y);
    it.pos_z    = 5'(z);
    it.sample_a = a;
    it.sample_b = b;
    return it;
  endfunction

  function automatic logic [15:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)  return 16'd0;
    if (roll < 12) return 16'hFFFF;
    if (roll < 16) return 16'd1;
    if (roll < 40) return 16'($urandom_range(255));
    return 16'($urandom);
  endfunction

  function automatic int jitter(input int v, input int span);
    int p;
    p = v + int'($urandom_range(2 * span)) - span;
    return (p < 0) ? 0 : (p > MAX_POS) ? MAX_POS : p;
  endfunction

  // Called on a falling edge; returns on the falling edge after the item is taken, with in_valid still high
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int c;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.kind == KIND_STORE) begin
      c             = vox(it.pos_x, it.pos_y, it.pos_z);
      first_vol[c]  = it.sample_a;
      second_vol[c] = it.sample_b;
      loaded[c]     = 1'b1;
    end else begin
      due_results.push_back(typed ? typed_res
                                  : percent_of_window(it.pos_x, it.pos_y, it.pos_z));
    end
    @(negedge clk);
  endtask

  task automatic store_pair(input int x, input int y, input int z,
                            input logic [15:0] a, input logic [15:0] b);
    push_item(make_item(KIND_STORE, x, y, z, a, b), 1'b0, '0);
  endtask

  // Queries only after every voxel that the block will read has been stored
  task automatic query_voxel(input int x, input int y, input int z);
    int r, c, i, j, k;
    if (!in_border(x, y, z)) begin
      c = vox(x, y, z);
      if (!loaded[c]) store_pair(x, y, z, pick_sample(), pick_sample());
      if (first_vol[c] != '0 && second_vol[c] != '0) begin
        r = eff_radius();
        for (k = z - r; k <= z + r; k++)
          for (j = y - r; j <= y + r; j++)
            for (i = x - r; i <= x + r; i++)
              if (!loaded[vox(i, j, k)]) store_pair(i, j, k, pick_sample(), pick_sample());
      end
    end
    push_item(make_item(KIND_QUERY, x, y, z, 16'($urandom), 16'($urandom)), 1'b0, '0);
  endtask

  // Sender holds off until every result has come or DRAIN_LIMIT is reached
  task automatic wait_for_results();
    int cycles;
    in_valid <= 1'b0;
    cycles = 0;
    while (due_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 6'(val);
    @(negedge clk);
    case (idx)
      CFG_DIM_X:  dim_reg[0] = 6'(val);
      CFG_DIM_Y:  dim_reg[1] = 6'(val);
      CFG_DIM_Z:  dim_reg[2] = 6'(val);
      CFG_RADIUS: radius_reg = 2'(val);
      default: ;
    endcase
  endtask

  // Mostly queries clustered around a hub so filled windows get reused
  task automatic random_phase(input int n_items);
    int  goal, r, a, roll, side;
    int  lo [3];
    int  hi [3];
    int  hub [3];
    int  p [3];
    bit  fresh;
    goal  = items_sent + n_items;
    r     = eff_radius();
    fresh = 1'b1;
    for (a = 0; a < 3; a++) begin
      lo[a] = r;
      hi[a] = eff_dim(dim_reg[a]) - 1 - r;
    end
    while (items_sent < goal) begin
      if (fresh) begin
        for (a = 0; a < 3; a++)
          hub[a] = (hi[a] >= lo[a]) ? int'($urandom_range(hi[a], lo[a]))
                                    : int'($urandom_range(MAX_POS));
        fresh = 1'b0;
      end
      for (a = 0; a < 3; a++) begin
        p[a] = jitter(hub[a], 2);
        if (hi[a] >= lo[a]) p[a] = (p[a] < lo[a]) ? lo[a] : (p[a] > hi[a]) ? hi[a] : p[a];
      end
      roll = $urandom_range(99);
      if (roll < 50) begin
        query_voxel(p[0], p[1], p[2]);
      end else if (roll < 64) begin
        // overwrite inside a window near the hub
        store_pair(jitter(p[0], r), jitter(p[1], r), jitter(p[2], r),
                   pick_sample(), pick_sample());
      end else if (roll < 74) begin
        store_pair($urandom_range(MAX_POS), $urandom_range(MAX_POS),
                   $urandom_range(MAX_POS), 16'($urandom), 16'($urandom));
      end else if (roll < 84) begin
        query_voxel($urandom_range(MAX_POS), $urandom_range(MAX_POS),
                    $urandom_range(MAX_POS));
      end else if (roll < 90) begin
        // zero centre sample in one volume
        if ($urandom_range(1)) store_pair(p[0], p[1], p[2], 16'd0, pick_sample());
        else store_pair(p[0], p[1], p[2], pick_sample(), 16'd0);
        query_voxel(p[0], p[1], p[2]);
      end else if (roll < 96) begin
        // just inside or outside the border band on one axis
        a    = $urandom_range(2);
        side = $urandom_range(1) ? eff_dim(dim_reg[a]) - r : r - 1;
        p[a] = $urandom_range(1) ? side : side + ($urandom_range(1) ? 1 : -1);
        p[a] = (p[a] < 0) ? 0 : (p[a] > MAX_POS) ? MAX_POS : p[a];
        query_voxel(p[0], p[1], p[2]);
      end else begin
        fresh = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int        ph, row, i, j, k;
    out_item_t want;
    dim_reg    = '{6'd32, 6'd32, 6'd32};
    radius_reg = 2'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 23;
    recv_idle = 56;

    // known flat window around the hub for the directed table
    for (k = HUB - 2; k <= HUB + 2; k++)
      for (j = HUB - 2; j <= HUB + 2; j++)
        for (i = HUB - 2; i <= HUB + 2; i++)
          store_pair(i, j, k, 16'd100, 16'd100);

    for (row = 0; row < DIR_ROWS; row++) begin
      want.diff_percent = 16'(DIRECTED[row][7]);
      want.status       = status_t'(DIRECTED[row][8]);
      push_item(make_item(1'(DIRECTED[row][0]), DIRECTED[row][1], DIRECTED[row][2],
                          DIRECTED[row][3], 16'(DIRECTED[row][4]), 16'(DIRECTED[row][5])),
                DIRECTED[row][6] != 0, want);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle = 56;
        recv_idle = 23;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_reg(CFG_DIM_X,  PHASES[ph][0]);
      write_reg(CFG_DIM_Y,  PHASES[ph][1]);
      write_reg(CFG_DIM_Z,  PHASES[ph][2]);
      write_reg(CFG_RADIUS, PHASES[ph][3]);
      cfg_we <= 1'b0;
      random_phase(PHASE_ITEMS);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));
    if (errors == 0) begin
      $display("[volume_window_percent_difference] OK");
    end else begin
      $display("[volume_window_percent_difference] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10ms;
    $display("[volume_window_percent_difference] ERROR");
    $finish;
  end

endmodule

// ----- volume_window_percent_difference.f -----
design/vwpd_pkg.sv
design/vwpd_ram.sv
design/vwpd_seq.sv
design/vwpd_dp.sv
design/volume_window_percent_difference.sv
dv/volume_window_percent_difference_test.sv
